[src/jpd_pkg.sv]
// ----------------------------------------------------------------------------
// jpd_pkg
// Types, register indexes and reset values for the joint PD torque block.
// ----------------------------------------------------------------------------
package jpd_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_MOVE      = 3'd0,
        CFG_TIME_STEP     = 3'd1,
        CFG_LIMIT_MARGIN  = 3'd2,
        CFG_LIMIT_P_SCALE = 3'd3,
        CFG_LIMIT_D_SCALE = 3'd4
    } t_cfg_idx;

    localparam logic [30:0] RST_MAX_MOVE      = 31'd65536;
    localparam logic [23:0] RST_TIME_STEP     = 24'd16777;
    localparam logic [30:0] RST_LIMIT_MARGIN  = 31'd66;
    localparam logic [30:0] RST_LIMIT_P_SCALE = 31'd655360;
    localparam logic [30:0] RST_LIMIT_D_SCALE = 31'd196608;

    // saturation bounds on a magnitude
    localparam logic [31:0] MAG_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAG_MAX_NEG = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] joint_pos;
        logic signed [31:0] joint_vel;
        logic signed [31:0] target_pos;
        logic        [30:0] stiffness_gain;
        logic        [30:0] damping_gain;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
    } t_joint_in;

    typedef struct packed {
        logic signed [31:0] prop_term;
        logic signed [31:0] damp_term;
        logic signed [31:0] clamped_target;
    } t_joint_out;

endpackage

[src/joint_pd_torque_with_limits.sv]
// Throughput: one joint per cycle; busy is never raised.
// Depth is set by the 62 x 57 bit proportional product, built from 32 x 32
// partial products over three stages, followed by rounding and saturation.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// joint_pd_torque_with_limits
// Per-joint PD torque terms with target clamping and joint-limit restoring
// terms, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module joint_pd_torque_with_limits
    import jpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_joint_in            i_data,
    output logic                 o_valid,
    output t_joint_out           o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [30:0] r_max_move;
    logic [23:0] r_time_step;
    logic [30:0] r_limit_margin;
    logic [30:0] r_limit_p_scale;
    logic [30:0] r_limit_d_scale;

    logic [8:0]  r_vld;
    logic        accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_move      <= RST_MAX_MOVE;
            r_time_step     <= RST_TIME_STEP;
            r_limit_margin  <= RST_LIMIT_MARGIN;
            r_limit_p_scale <= RST_LIMIT_P_SCALE;
            r_limit_d_scale <= RST_LIMIT_D_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_MOVE:      r_max_move      <= i_cfg_data[30:0];
                CFG_TIME_STEP:     r_time_step     <= i_cfg_data[23:0];
                CFG_LIMIT_MARGIN:  r_limit_margin  <= i_cfg_data[30:0];
                CFG_LIMIT_P_SCALE: r_limit_p_scale <= i_cfg_data[30:0];
                CFG_LIMIT_D_SCALE: r_limit_d_scale <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], accept};
        end
    end

    // stage 1
    logic signed [31:0] r_tgt_l,  n_tgt_l;
    logic signed [33:0] r_mm_lo,  n_mm_lo;
    logic signed [33:0] r_mm_hi,  n_mm_hi;
    logic               r_use_lim, n_use_lim;
    logic signed [31:0] r_lim,    n_lim;
    logic        [61:0] r_gp,     n_gp;
    logic        [61:0] r_gd,     n_gd;
    logic signed [56:0] r_vh,     n_vh;
    logic signed [31:0] r_pos1, r_vel1;
    logic        [30:0] r_kp1, r_kd1;

    always_comb begin
        logic signed [32:0] pos33;
        logic signed [32:0] low_m;
        logic signed [32:0] upp_m;
        logic               below;
        logic               above;
        pos33 = {i_data.joint_pos[31], i_data.joint_pos};
        low_m = $signed({i_data.lower_limit[31], i_data.lower_limit})
              - $signed({2'b00, r_limit_margin});
        upp_m = $signed({i_data.upper_limit[31], i_data.upper_limit})
              + $signed({2'b00, r_limit_margin});
        if (i_data.target_pos < i_data.lower_limit) begin
            n_tgt_l = i_data.lower_limit;
        end else if (i_data.target_pos > i_data.upper_limit) begin
            n_tgt_l = i_data.upper_limit;
        end else begin
            n_tgt_l = i_data.target_pos;
        end
        n_mm_lo = $signed({{2{i_data.joint_pos[31]}}, i_data.joint_pos})
                - $signed({3'b000, r_max_move});
        n_mm_hi = $signed({{2{i_data.joint_pos[31]}}, i_data.joint_pos})
                + $signed({3'b000, r_max_move});
        below = (pos33 <= low_m) && i_data.joint_vel[31];
        above = (upp_m <= pos33) && !i_data.joint_vel[31] && (i_data.joint_vel != 32'sd0);
        n_use_lim = below || above;
        n_lim     = below ? i_data.lower_limit : i_data.upper_limit;
        n_gp      = i_data.stiffness_gain * r_limit_p_scale;
        n_gd      = i_data.damping_gain * r_limit_d_scale;
        n_vh      = $signed(i_data.joint_vel) * $signed({1'b0, r_time_step});
    end

    // stage 2
    logic signed [31:0] r_tgt2,   n_tgt2;
    logic signed [31:0] r_ref,    n_ref;
    logic signed [57:0] r_base,   n_base;
    logic        [61:0] r_gain_p, n_gain_p;
    logic        [61:0] r_gain_d, n_gain_d;
    logic        [31:0] r_vmag,   n_vmag;
    logic               r_dneg2,  n_dneg2;

    always_comb begin
        logic signed [33:0] t;
        t = {{2{r_tgt_l[31]}}, r_tgt_l};
        if (t < r_mm_lo) begin
            t = r_mm_lo;
        end
        if (t > r_mm_hi) begin
            t = r_mm_hi;
        end
        // bounds lie between the limit-clamped target and pos: always in range
        n_tgt2   = t[31:0];
        n_ref    = r_use_lim ? r_lim : n_tgt2;
        n_base   = $signed({{2{r_pos1[31]}}, r_pos1, 24'd0}) + $signed({r_vh[56], r_vh});
        n_gain_p = r_use_lim ? r_gp : {15'd0, r_kp1, 16'd0};
        n_gain_d = r_use_lim ? r_gd : {15'd0, r_kd1, 16'd0};
        n_vmag   = r_vel1[31] ? (32'd0 - r_vel1) : r_vel1;
        n_dneg2  = !r_vel1[31] && (r_vel1 != 32'sd0);
    end

    // stage 3
    logic signed [57:0] r_e,   n_e;
    logic        [63:0] r_pd0, n_pd0;
    logic        [61:0] r_pd1, n_pd1;
    logic        [61:0] r_gain_p3;
    logic               r_dneg3;
    logic signed [31:0] r_tgt3;

    always_comb begin
        n_e   = r_base - $signed({{2{r_ref[31]}}, r_ref, 24'd0});
        n_pd0 = r_gain_d[31:0] * r_vmag;
        n_pd1 = r_gain_d[61:32] * r_vmag;
    end

    // stage 4
    logic        [56:0] r_emag, n_emag;
    logic               r_pneg4, n_pneg4;
    logic        [93:0] r_dsum, n_dsum;
    logic        [61:0] r_gain_p4;
    logic               r_dneg4;
    logic signed [31:0] r_tgt4;

    always_comb begin
        logic [57:0] mag;
        mag     = r_e[57] ? (58'd0 - r_e) : r_e;
        n_emag  = mag[56:0];
        n_pneg4 = !r_e[57] && (r_e != 58'sd0);
        n_dsum  = {30'd0, r_pd0} + {r_pd1, 32'd0};
    end

    // stage 5
    logic        [63:0] r_pp00, n_pp00;
    logic        [56:0] r_pp01, n_pp01;
    logic        [61:0] r_pp10, n_pp10;
    logic        [54:0] r_pp11, n_pp11;
    logic        [31:0] r_dq,   n_dq;
    logic               r_dneg5;
    logic               r_pneg5;
    logic signed [31:0] r_tgt5;

    always_comb begin
        logic [93:0] rd;
        logic [31:0] lim;
        n_pp00 = r_gain_p4[31:0]  * r_emag[31:0];
        n_pp01 = r_gain_p4[31:0]  * r_emag[56:32];
        n_pp10 = r_gain_p4[61:32] * r_emag[31:0];
        n_pp11 = r_gain_p4[61:32] * r_emag[56:32];
        rd     = r_dsum + (94'd1 << 31);
        lim    = r_dneg4 ? MAG_MAX_NEG : MAG_MAX_POS;
        n_dq   = (rd[93:32] > {30'd0, lim}) ? lim : rd[63:32];
    end

    // stage 6
    logic        [62:0] r_mid,  n_mid;
    logic        [63:0] r_pp00_6;
    logic        [54:0] r_pp11_6;
    logic signed [31:0] r_damp6, n_damp6;
    logic               r_pneg6;
    logic signed [31:0] r_tgt6;

    always_comb begin
        n_mid   = {6'd0, r_pp01} + {1'b0, r_pp10};
        n_damp6 = r_dneg5 ? (32'd0 - r_dq) : r_dq;
    end

    // stage 7
    logic       [119:0] r_psum, n_psum;
    logic signed [31:0] r_damp7;
    logic               r_pneg7;
    logic signed [31:0] r_tgt7;

    always_comb begin
        n_psum = {1'b0, r_pp11_6, r_pp00_6} + {25'd0, r_mid, 32'd0};
    end

    // stage 8
    logic        [31:0] r_pq, n_pq;
    logic signed [31:0] r_damp8;
    logic               r_pneg8;
    logic signed [31:0] r_tgt8;

    always_comb begin
        logic [119:0] rp;
        logic [31:0]  lim;
        rp   = r_psum + (120'd1 << 55);
        lim  = r_pneg7 ? MAG_MAX_NEG : MAG_MAX_POS;
        n_pq = (rp[119:56] > {32'd0, lim}) ? lim : rp[87:56];
    end

    // stage 9
    t_joint_out r_out, n_out;

    always_comb begin
        n_out.prop_term      = r_pneg8 ? (32'd0 - r_pq) : r_pq;
        n_out.damp_term      = r_damp8;
        n_out.clamped_target = r_tgt8;
    end

    always_ff @(posedge i_clk) begin
        r_tgt_l   <= n_tgt_l;
        r_mm_lo   <= n_mm_lo;
        r_mm_hi   <= n_mm_hi;
        r_use_lim <= n_use_lim;
        r_lim     <= n_lim;
        r_gp      <= n_gp;
        r_gd      <= n_gd;
        r_vh      <= n_vh;
        r_pos1    <= i_data.joint_pos;
        r_vel1    <= i_data.joint_vel;
        r_kp1     <= i_data.stiffness_gain;
        r_kd1     <= i_data.damping_gain;

        r_tgt2    <= n_tgt2;
        r_ref     <= n_ref;
        r_base    <= n_base;
        r_gain_p  <= n_gain_p;
        r_gain_d  <= n_gain_d;
        r_vmag    <= n_vmag;
        r_dneg2   <= n_dneg2;

        r_e       <= n_e;
        r_pd0     <= n_pd0;
        r_pd1     <= n_pd1;
        r_gain_p3 <= r_gain_p;
        r_dneg3   <= r_dneg2;
        r_tgt3    <= r_tgt2;

        r_emag    <= n_emag;
        r_pneg4   <= n_pneg4;
        r_dsum    <= n_dsum;
        r_gain_p4 <= r_gain_p3;
        r_dneg4   <= r_dneg3;
        r_tgt4    <= r_tgt3;

        r_pp00    <= n_pp00;
        r_pp01    <= n_pp01;
        r_pp10    <= n_pp10;
        r_pp11    <= n_pp11;
        r_dq      <= n_dq;
        r_dneg5   <= r_dneg4;
        r_pneg5   <= r_pneg4;
        r_tgt5    <= r_tgt4;

        r_mid     <= n_mid;
        r_pp00_6  <= r_pp00;
        r_pp11_6  <= r_pp11;
        r_damp6   <= n_damp6;
        r_pneg6   <= r_pneg5;
        r_tgt6    <= r_tgt5;

        r_psum    <= n_psum;
        r_damp7   <= r_damp6;
        r_pneg7   <= r_pneg6;
        r_tgt7    <= r_tgt6;

        r_pq      <= n_pq;
        r_damp8   <= r_damp7;
        r_pneg8   <= r_pneg7;
        r_tgt8    <= r_tgt7;

        r_out     <= n_out;
    end

    assign o_valid = r_vld[8];
    assign o_data  = r_out;

    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 9))
        else $error("result strobe without a start beat nine cycles earlier");

    a_target_in_move_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> ($signed({{2{r_tgt2[31]}}, r_tgt2}) >= $past(r_mm_lo))
                  && ($signed({{2{r_tgt2[31]}}, r_tgt2}) <= $past(r_mm_hi)))
        else $error("clamped target outside the max-move window");

    a_prop_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (r_pq <= (r_pneg8 ? MAG_MAX_NEG : MAG_MAX_POS)))
        else $error("proportional magnitude beyond saturation bound");

    a_damp_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_dq <= (r_dneg5 ? MAG_MAX_NEG : MAG_MAX_POS)))
        else $error("damping magnitude beyond saturation bound");

endmodule

[dv/jpd_torque_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpd_torque_checker
// Watches the joint, torque and register channels of the joint PD block.
// Keeps its own copy of the registers, predicts the torque terms and the
// clamped target of every accepted joint beat, and compares each result
// strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module jpd_torque_checker
    import jpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_joint_in            i_joint,
    input  logic                 i_valid,
    input  t_joint_out           i_torque,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [30:0] max_move_q;
    logic [23:0] time_step_q;
    logic [30:0] margin_q;
    logic [30:0] p_scale_q;
    logic [30:0] d_scale_q;

    t_joint_out  torque_queue [$];
    int          fails;
    string       field_name [3] = '{"prop_term", "damp_term", "clamped_target"};

    // -(gain * val) / 2^sh, rounded half away from zero, saturated to 32 bits
    function automatic logic [31:0] neg_scaled(logic [63:0] gain, longint val,
                                               int unsigned sh);
        logic [63:0]  mag;
        logic [127:0] q;
        logic [31:0]  lim;
        logic         neg;
        neg = (val > 0);
        mag = (val < 0) ? 64'(-val) : 64'(val);
        q   = ({64'd0, gain} * {64'd0, mag} + (128'd1 << (sh - 1))) >> sh;
        lim = neg ? MAG_MAX_NEG : MAG_MAX_POS;
        if (q > {96'd0, lim}) begin
            q = {96'd0, lim};
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_joint_out predict_torque(t_joint_in d);
        longint     pos, vel, tgt, lower, upper, mm, mg, h, err, lim;
        logic [63:0] kp, kd;
        logic        below, above;
        t_joint_out  r;
        pos   = d.joint_pos;
        vel   = d.joint_vel;
        tgt   = d.target_pos;
        lower = d.lower_limit;
        upper = d.upper_limit;
        kp    = {33'd0, d.stiffness_gain};
        kd    = {33'd0, d.damping_gain};
        mm    = max_move_q;
        mg    = margin_q;
        h     = time_step_q;

        // with inverted limits, a target below the lower limit takes it, any other the upper
        if (tgt < lower) begin
            tgt = lower;
        end else if (tgt > upper) begin
            tgt = upper;
        end
        if (tgt < pos - mm) begin
            tgt = pos - mm;
        end
        if (tgt > pos + mm) begin
            tgt = pos + mm;
        end
        if (tgt > 64'sd2147483647) begin
            tgt = 64'sd2147483647;
        end
        if (tgt < -64'sd2147483648) begin
            tgt = -64'sd2147483648;
        end

        err = (pos - tgt) * 64'sd16777216 + vel * h;
        r.prop_term = neg_scaled(kp, err, 40);
        r.damp_term = neg_scaled(kd, vel, 16);

        if (!(lower - mg < pos && pos < upper + mg)) begin
            below = (pos <= lower - mg) && (vel < 0);
            above = (upper + mg <= pos) && (vel > 0);
            if (below || above) begin
                lim = below ? lower : upper;
                err = (pos - lim) * 64'sd16777216 + vel * h;
                r.prop_term = neg_scaled(kp * {33'd0, p_scale_q}, err, 56);
                r.damp_term = neg_scaled(kd * {33'd0, d_scale_q}, vel, 32);
            end
        end
        r.clamped_target = tgt[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_joint_out  want;
        logic [31:0] w;
        logic [31:0] g;
        if (!i_rst_n) begin
            max_move_q  = RST_MAX_MOVE;
            time_step_q = RST_TIME_STEP;
            margin_q    = RST_LIMIT_MARGIN;
            p_scale_q   = RST_LIMIT_P_SCALE;
            d_scale_q   = RST_LIMIT_D_SCALE;
            torque_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_MOVE:      max_move_q  = i_cfg_data[30:0];
                    CFG_TIME_STEP:     time_step_q = i_cfg_data[23:0];
                    CFG_LIMIT_MARGIN:  margin_q    = i_cfg_data[30:0];
                    CFG_LIMIT_P_SCALE: p_scale_q   = i_cfg_data[30:0];
                    CFG_LIMIT_D_SCALE: d_scale_q   = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                torque_queue.push_back(predict_torque(i_joint));
            end
            if (i_valid) begin
                if (torque_queue.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_torque);
                    fails++;
                end else begin
                    want = torque_queue.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        w = want[95 - 32 * k -: 32];
                        g = i_torque[95 - 32 * k -: 32];
                        if (w !== g) begin
                            $display("%0t: %s mismatch: expected %h actual %h",
                                     $time, field_name[k], w, g);
                            fails++;
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= torque_queue.size();
    end

endmodule

[dv/joint_pd_torque_with_limits_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_pd_torque_with_limits_test
// Drives joint beats and register writes into the joint PD block: a directed
// set of corner joints under the reset registers, then random joints over
// several register settings, with random bubbles on the start side in all phases but one.
// ----------------------------------------------------------------------------
module joint_pd_torque_with_limits_test;
    import jpd_pkg::*;

    localparam int LATENCY         = 9;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int NO_GAP_PHASE    = 4;
    localparam int IDLE_PCT        = 12;
    localparam int WATCHDOG_LIMIT  = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

    localparam logic signed [31:0] ONE     = 32'sh0001_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic        [31:0] G_MAX   = 32'h7FFF_FFFF;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    t_joint_in            joint_in;
    logic                 torque_valid;
    t_joint_out           torque;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    bit                   gaps_on;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    joint_pd_torque_with_limits dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_data      (joint_in),
        .o_valid     (torque_valid),
        .o_data      (torque),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    jpd_torque_checker torque_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_joint      (joint_in),
        .i_valid      (torque_valid),
        .i_torque     (torque),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if ((start && !busy) || torque_valid || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** joint_pd_torque_with_limits: FAILED **");
            $finish;
        end
    end

    // magnitudes spread over all scales
    function automatic logic [31:0] spread_mag();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic signed [31:0] signed_spread();
        logic [31:0] m;
        m = spread_mag();
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic t_joint_in make_joint(logic signed [31:0] pos, logic signed [31:0] vel,
                                             logic signed [31:0] tgt, logic [31:0] kp,
                                             logic [31:0] kd, logic signed [31:0] lo,
                                             logic signed [31:0] hi);
        t_joint_in d;
        d.joint_pos      = pos;
        d.joint_vel      = vel;
        d.target_pos     = tgt;
        d.stiffness_gain = kp[30:0];
        d.damping_gain   = kd[30:0];
        d.lower_limit    = lo;
        d.upper_limit    = hi;
        return d;
    endfunction

    function automatic t_joint_in random_joint();
        t_joint_in          d;
        logic signed [31:0] anchor;
        if ($urandom_range(0, 3) == 0) begin
            d.joint_pos      = $urandom;
            d.joint_vel      = $urandom;
            d.target_pos     = $urandom;
            d.stiffness_gain = 31'($urandom);
            d.damping_gain   = 31'($urandom);
            d.lower_limit    = $urandom;
            d.upper_limit    = $urandom;
            return d;
        end
        d.lower_limit = signed_spread() >>> 2;
        if ($urandom_range(0, 15) == 0) begin
            d.upper_limit = d.lower_limit - (spread_mag() >> 2);
        end else begin
            d.upper_limit = d.lower_limit + (spread_mag() >> 2);
        end
        case ($urandom_range(0, 2))
            0:       anchor = d.lower_limit;
            1:       anchor = d.upper_limit;
            default: anchor = d.lower_limit + ((d.upper_limit - d.lower_limit) >>> 1);
        endcase
        // position near a limit or the midpoint, at a random distance on either side
        d.joint_pos = anchor + (signed_spread() >>> $urandom_range(1, 12));
        d.joint_vel = ($urandom_range(0, 7) == 0) ? 32'sd0 : signed_spread();
        if ($urandom_range(0, 3) == 0) begin
            d.target_pos = $urandom;
        end else begin
            d.target_pos = d.joint_pos + (signed_spread() >>> 1);
        end
        d.stiffness_gain = 31'(spread_mag());
        d.damping_gain   = 31'(spread_mag());
        return d;
    endfunction

    task automatic send_joint(t_joint_in d);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            start    <= 1'b0;
            joint_in <= random_joint();
            @(posedge clk);
        end
        start    <= 1'b1;
        joint_in <= d;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // leaves valid high; caller drops it after the last beat
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        if (idx == CFG_TIME_STEP) begin
            mask = 32'h00FF_FFFF;
        end else if (idx == CFG_IDX_SPARE) begin
            mask = 32'h0000_0000;
        end else begin
            mask = 32'h7FFF_FFFF;
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (value & mask) | ($urandom & ~mask);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_registers(int phase);
        logic [31:0] value;
        for (int r = CFG_MAX_MOVE; r <= CFG_LIMIT_D_SCALE; r++) begin
            if (phase == 1) begin
                value = 32'hFFFF_FFFF;
            end else if (phase == 2) begin
                value = 32'h0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       value = 32'h0;
                    1:       value = 32'hFFFF_FFFF;
                    default: value = spread_mag();
                endcase
            end
            write_reg(CFG_IDX_W'(r), value);
        end
        write_reg(CFG_IDX_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        joint_in  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAX_MOVE;
        cfg_data  <= '0;
        gaps_on   = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_joint(make_joint(0, 0, 0, 0, 0, 0, 0));
        send_joint(make_joint(S32_MAX, S32_MAX, S32_MAX, G_MAX, G_MAX, S32_MAX, S32_MAX));
        send_joint(make_joint(S32_MIN, S32_MIN, S32_MIN, 0, 0, S32_MIN, S32_MIN));
        // inverted limits
        send_joint(make_joint(0, ONE, -2 * ONE, ONE, ONE, ONE, -ONE));
        send_joint(make_joint(0, -ONE, 2 * ONE, ONE, ONE, ONE, -ONE));
        // max move past the 32 bit range
        send_joint(make_joint(S32_MAX - 100, ONE, S32_MAX, G_MAX, ONE, S32_MIN, S32_MAX));
        send_joint(make_joint(S32_MIN + 100, -ONE, S32_MIN, G_MAX, ONE, S32_MIN, S32_MAX));
        // beyond a limit: outward, inward, at rest
        send_joint(make_joint(-32'sh1000, -32'sh8000, 0, 100 * ONE, 2 * ONE, 0, 16 * ONE));
        send_joint(make_joint(16 * ONE + 32'sh1000, 32'sh8000, 16 * ONE, 100 * ONE, 2 * ONE,
                              0, 16 * ONE));
        send_joint(make_joint(-32'sh1000, 32'sh8000, 0, 100 * ONE, 2 * ONE, 0, 16 * ONE));
        send_joint(make_joint(16 * ONE + 32'sh1000, -32'sh8000, 16 * ONE, 100 * ONE, 2 * ONE,
                              0, 16 * ONE));
        send_joint(make_joint(-32'sh1000, 0, 0, 100 * ONE, 2 * ONE, 0, 16 * ONE));
        // margin edges
        send_joint(make_joint(-66, -1, 0, 100 * ONE, 2 * ONE, 0, 16 * ONE));
        send_joint(make_joint(-65, -1, 0, 100 * ONE, 2 * ONE, 0, 16 * ONE));
        send_joint(make_joint(16 * ONE + 66, 1, 0, 100 * ONE, 2 * ONE, 0, 16 * ONE));
        // saturation
        send_joint(make_joint(S32_MAX, S32_MAX, S32_MIN, G_MAX, 0, S32_MIN, S32_MAX));
        send_joint(make_joint(S32_MIN, S32_MIN, S32_MAX, G_MAX, 0, S32_MIN, S32_MAX));
        send_joint(make_joint(0, S32_MIN, 0, 0, G_MAX, S32_MIN, S32_MAX));
        send_joint(make_joint(-ONE, S32_MIN, 0, G_MAX, G_MAX, 0, ONE));
        // rounding ties
        send_joint(make_joint(0, 32'sh8000, 0, 0, 1, S32_MIN, S32_MAX));
        send_joint(make_joint(0, -32'sh8000, 0, 0, 1, S32_MIN, S32_MAX));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                program_registers(phase);
            end
            gaps_on = (phase != NO_GAP_PHASE);
            repeat (ITEMS_PER_PHASE) send_joint(random_joint());
        end

        settle();
        if (fail_count == 0) begin
            $display("** joint_pd_torque_with_limits: PASSED **");
        end else begin
            $display("** joint_pd_torque_with_limits: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
src/jpd_pkg.sv
src/joint_pd_torque_with_limits.sv
dv/jpd_torque_checker.sv
dv/joint_pd_torque_with_limits_test.sv
